[sv/tdds_pkg.sv]
// Shared constants, codes, the frequency step table and struct types of the
// table DDS function generator. No dependencies.
package tdds_pkg;

  localparam int PHASE_ONE   = 65536;
  localparam int SAMPLE_RATE = 100000;
  localparam int NUM_FREQS   = 8;
  localparam int NUM_WAVES   = 5;

  localparam int PHASE_W     = 16;
  localparam int IDX_W       = 8;
  localparam int WAVE_W      = 3;
  localparam int FREQ_W      = 3;
  localparam int SAMPLE_W    = 12;
  localparam int ADDR_W      = WAVE_W + IDX_W;
  localparam int TABLE_LEN   = 256;
  localparam int TABLE_DEPTH = NUM_WAVES * TABLE_LEN;
  localparam int RESET_FREQ  = (NUM_FREQS > 3) ? 3 : NUM_FREQS - 1;

  // request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_NAV  = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  // navigation directions
  localparam logic [2:0] DIR_NORTH = 3'd1;
  localparam logic [2:0] DIR_SOUTH = 3'd2;
  localparam logic [2:0] DIR_EAST  = 3'd3;
  localparam logic [2:0] DIR_WEST  = 3'd4;

  localparam longint FREQ_HZ [8] = '{10, 20, 50, 100, 200, 500, 1000, 2000};

  // truncated steps, freq * PHASE_ONE / SAMPLE_RATE, all constant
  localparam longint STEP_RAW [8] = '{
    FREQ_HZ[0] * PHASE_ONE / SAMPLE_RATE, FREQ_HZ[1] * PHASE_ONE / SAMPLE_RATE,
    FREQ_HZ[2] * PHASE_ONE / SAMPLE_RATE, FREQ_HZ[3] * PHASE_ONE / SAMPLE_RATE,
    FREQ_HZ[4] * PHASE_ONE / SAMPLE_RATE, FREQ_HZ[5] * PHASE_ONE / SAMPLE_RATE,
    FREQ_HZ[6] * PHASE_ONE / SAMPLE_RATE, FREQ_HZ[7] * PHASE_ONE / SAMPLE_RATE
  };

  // saturate a step to the accumulator width
  function automatic logic [PHASE_W-1:0] sat_step(longint s);
    return (s > 65535) ? 16'hFFFF : s[PHASE_W-1:0];
  endfunction

  localparam logic [PHASE_W-1:0] STEP_TBL [8] = '{
    sat_step(STEP_RAW[0]), sat_step(STEP_RAW[1]), sat_step(STEP_RAW[2]),
    sat_step(STEP_RAW[3]), sat_step(STEP_RAW[4]), sat_step(STEP_RAW[5]),
    sat_step(STEP_RAW[6]), sat_step(STEP_RAW[7])
  };

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [SAMPLE_W-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic [WAVE_W-1:0] wave;
    logic [FREQ_W-1:0] freq;
  } sel_t;

endpackage

[sv/tdds_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on tdds_pkg for field widths.
interface tdds_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [2:0]                     direction;
  logic [tdds_pkg::WAVE_W-1:0]    load_wave;
  logic [tdds_pkg::IDX_W-1:0]     load_index;
  logic [tdds_pkg::SAMPLE_W-1:0]  load_value;

  modport source(output valid, req_type, direction, load_wave, load_index, load_value,
                 input ready);
  modport sink(input valid, req_type, direction, load_wave, load_index, load_value,
               output ready);
endinterface

interface tdds_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tdds_pkg::SAMPLE_W-1:0]  dac_sample;
  logic [tdds_pkg::WAVE_W-1:0]    wave_now;
  logic [tdds_pkg::FREQ_W-1:0]    freq_now;

  modport source(output valid, dac_sample, wave_now, freq_now, input ready);
  modport sink(input valid, dac_sample, wave_now, freq_now, output ready);
endinterface

[sv/tdds_wave_ram.sv]
// Single-port synchronous RAM with registered read.
// Generic; no package dependency.
module tdds_wave_ram #(
  parameter int DEPTH = 1280,
  parameter int WIDTH = 12,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[sv/tdds_ctrl.sv]
// Phase accumulator and waveform/frequency selection; issues table reads
// on ticks and table writes on loads. Depends on tdds_pkg.
module tdds_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    req_type,
  input  logic [2:0]                    direction,
  input  logic [tdds_pkg::WAVE_W-1:0]   load_wave,
  input  logic [tdds_pkg::IDX_W-1:0]    load_index,
  input  logic [tdds_pkg::SAMPLE_W-1:0] load_value,
  output tdds_pkg::mem_cmd_t            cmd,
  output tdds_pkg::sel_t                sel
);

  logic [tdds_pkg::PHASE_W-1:0] phase_acc, phase_acc_next, acc_sum;
  logic [tdds_pkg::PHASE_W-1:0] phase_step;
  logic [tdds_pkg::WAVE_W-1:0]  wave_sel, wave_sel_next, wave_up, wave_dn;
  logic [tdds_pkg::FREQ_W-1:0]  freq_sel, freq_sel_next, freq_up, freq_dn;

  assign acc_sum = phase_acc + phase_step;

  assign freq_up = ({1'b0, freq_sel} + 4'd1 >= 4'(tdds_pkg::NUM_FREQS)) ?
                   '0 : freq_sel + 3'd1;
  assign freq_dn = (freq_sel == '0) ? 3'(tdds_pkg::NUM_FREQS - 1) : freq_sel - 3'd1;
  assign wave_up = ({1'b0, wave_sel} + 4'd1 >= 4'(tdds_pkg::NUM_WAVES)) ?
                   '0 : wave_sel + 3'd1;
  assign wave_dn = (wave_sel == '0) ? 3'(tdds_pkg::NUM_WAVES - 1) : wave_sel - 3'd1;

  always_comb begin
    phase_acc_next = phase_acc;
    wave_sel_next  = wave_sel;
    freq_sel_next  = freq_sel;
    cmd.rd         = 1'b0;
    cmd.wr         = 1'b0;
    cmd.addr       = {load_wave, load_index};
    cmd.wdata      = load_value;
    if (accept) begin
      case (req_type)
        tdds_pkg::REQ_TICK: begin
          phase_acc_next = acc_sum;
          cmd.rd         = 1'b1;
          cmd.addr       = {wave_sel, acc_sum[tdds_pkg::PHASE_W-1 -: tdds_pkg::IDX_W]};
        end
        tdds_pkg::REQ_NAV: begin
          case (direction)
            tdds_pkg::DIR_NORTH: freq_sel_next = freq_up;
            tdds_pkg::DIR_SOUTH: freq_sel_next = freq_dn;
            tdds_pkg::DIR_EAST:  wave_sel_next = wave_up;
            tdds_pkg::DIR_WEST:  wave_sel_next = wave_dn;
            default: ;
          endcase
        end
        tdds_pkg::REQ_LOAD: begin
          cmd.wr = ({1'b0, load_wave} < 4'(tdds_pkg::NUM_WAVES));
        end
        default: ;
      endcase
    end
  end

  assign sel.wave = wave_sel_next;
  assign sel.freq = freq_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      phase_step <= tdds_pkg::STEP_TBL[tdds_pkg::RESET_FREQ];
      wave_sel   <= '0;
      freq_sel   <= 3'(tdds_pkg::RESET_FREQ);
    end else if (accept) begin
      phase_acc  <= phase_acc_next;
      phase_step <= tdds_pkg::STEP_TBL[freq_sel_next];
      wave_sel   <= wave_sel_next;
      freq_sel   <= freq_sel_next;
    end
  end

endmodule

[sv/table_dds_function_generator.sv]
// Table-based DDS function generator: top level.
// Depends on tdds_pkg, tdds_if, tdds_ctrl, tdds_wave_ram.
//
// Usage:
//   req (sink) carries one request per transfer: a sample tick, a navigation
//   event (north/south step the frequency list, east/west the waveform list,
//   both with wrap) or a waveform table write. rsp (source) returns exactly
//   one result per request: the held DAC sample, the selected waveform and
//   the selected frequency index after that request took effect.
//   A tick advances the 16-bit phase accumulator by the current step and
//   reads the entry addressed by {waveform, phase[15:8]}; the result of a
//   tick carries that entry, other results repeat the last tick's sample.
// Timing:
//   A request passes the read stage and the output register before it
//   shows up on rsp. One request per cycle is sustained while rsp.ready is
//   high; the limit is the single table RAM port, used at most once per
//   request (read on ticks, write on loads), with read data the next cycle.
// Reset (rst, synchronous): phase 0, sine, 100 Hz, held sample 0, both
//   pipeline stages empty. Table contents are not cleared; load every entry
//   before ticking through it.
// Stall: rsp holds its result while rsp.ready is low. The read stage keeps
//   one more item, so req.ready drops only when both stages are full.
module table_dds_function_generator (
  input  logic       clk,
  input  logic       rst,
  tdds_req_if.sink   req,
  tdds_rsp_if.source rsp
);

  tdds_pkg::mem_cmd_t cmd;
  tdds_pkg::sel_t     sel;

  logic accept;
  logic s1_adv;

  // read stage: table data lands here the cycle after the request
  logic                          s1_valid;
  logic                          s1_tick;
  tdds_pkg::sel_t                s1_sel;
  logic [tdds_pkg::SAMPLE_W-1:0] rdata;

  // output register
  logic                          out_valid;
  logic [tdds_pkg::SAMPLE_W-1:0] out_sample;
  tdds_pkg::sel_t                out_sel;
  logic [tdds_pkg::SAMPLE_W-1:0] held_sample;

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  tdds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req.req_type),
    .direction  (req.direction),
    .load_wave  (req.load_wave),
    .load_index (req.load_index),
    .load_value (req.load_value),
    .cmd        (cmd),
    .sel        (sel)
  );

  // read only when a tick is issued, so rdata holds through a stall
  tdds_wave_ram #(
    .DEPTH (tdds_pkg::TABLE_DEPTH),
    .WIDTH (tdds_pkg::SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .en    (cmd.rd || cmd.wr),
    .we    (cmd.wr),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tick <= (req.req_type == tdds_pkg::REQ_TICK);
      s1_sel  <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      held_sample <= '0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
      if (s1_valid && s1_tick) begin
        held_sample <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_sample <= s1_tick ? rdata : held_sample;
      out_sel    <= s1_sel;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.dac_sample = out_sample;
  assign rsp.wave_now   = out_sel.wave;
  assign rsp.freq_now   = out_sel.freq;

`ifndef SYNTHESIS
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!s1_valid || s1_adv))
    else $error("request transferred with read stage blocked");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("read stage item lost during stall");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && !s1_tick) |=> $stable(held_sample))
    else $error("held sample changed on a non-tick item");

  a_wave_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_sel.wave} < 4'(tdds_pkg::NUM_WAVES)))
    else $error("selected waveform out of range");
`endif

endmodule

[tb/tb_table_dds_function_generator.sv]
// Self-checking testbench for the table DDS function generator.
// Depends on tdds_pkg, tdds_if and the table_dds_function_generator RTL.
// Fills each table entry just before the first tick that reads it.
module tb_table_dds_function_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import tdds_pkg::*;

  // Codes the package does not name: the spare request kind and
  // two of the directions that a navigation event ignores.
  localparam logic [1:0] REQ_SPARE  = 2'd3;
  localparam logic [2:0] DIR_NONE   = 3'd0;
  localparam logic [2:0] DIR_SPARE  = 3'd7;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES  = 10;    // read stage and output register plus margin
  localparam int RANDOM_ITEMS = 600;

  localparam int HZ_LIST [8] = '{10, 20, 50, 100, 200, 500, 1000, 2000};

  typedef struct {
    logic [1:0]          kind;
    logic [2:0]          dir;
    logic [WAVE_W-1:0]   wave;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
  } dds_req_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [WAVE_W-1:0]   wave;
    logic [FREQ_W-1:0]   freq;
  } dds_out_t;

  logic clk;
  logic rst;

  tdds_req_if req ();
  tdds_rsp_if rsp ();

  table_dds_function_generator DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Generator shadow: phase accumulator, step, selections, tables, held sample.
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]  gen_phase;
  logic [PHASE_W-1:0]  gen_step;
  logic [WAVE_W-1:0]   gen_wave;
  logic [FREQ_W-1:0]   gen_freq;
  logic [SAMPLE_W-1:0] gen_sample;
  logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

  // Planning shadow, run as requests are queued: tracks which entries
  // the upcoming ticks will read and which are written by then.
  logic [PHASE_W-1:0]  plan_phase;
  logic [PHASE_W-1:0]  plan_step;
  logic [WAVE_W-1:0]   plan_wave;
  logic [FREQ_W-1:0]   plan_freq;
  bit                  plan_written [TABLE_DEPTH];

  dds_req_t pending_reqs [$];
  dds_out_t expected_outputs [$];
  dds_req_t cur_req;

  int send_idle_pct;
  int recv_idle_pct;
  int n_ticks, n_navs, n_loads, n_other, n_results, n_errors;
  int n_queued;
  int idle_cycles;

  // Phase increment per sample for a frequency index, truncated, saturated.
  function automatic logic [PHASE_W-1:0] phase_increment(int unsigned f);
    longint q;
    q = longint'(HZ_LIST[f]) * longint'(PHASE_ONE) / longint'(SAMPLE_RATE);
    if (q > 65535) q = 65535;
    return q[PHASE_W-1:0];
  endfunction

  // Applies one accepted request to the shadow and returns the outputs it yields.
  function automatic dds_out_t advance_generator(dds_req_t r);
    dds_out_t o;
    case (r.kind)
      REQ_TICK: begin
        gen_phase  = gen_phase + gen_step;  // wraps mod 2^16
        gen_sample = wave_mem[gen_wave * TABLE_LEN + gen_phase[15:8]];
        n_ticks++;
      end
      REQ_NAV: begin
        case (r.dir)
          DIR_NORTH: begin
            gen_freq = (gen_freq + 1 >= NUM_FREQS) ? '0 : gen_freq + 1'b1;
            gen_step = phase_increment(gen_freq);
          end
          DIR_SOUTH: begin
            gen_freq = (gen_freq == 0) ? FREQ_W'(NUM_FREQS - 1) : gen_freq - 1'b1;
            gen_step = phase_increment(gen_freq);
          end
          DIR_EAST: gen_wave = (gen_wave + 1 >= NUM_WAVES) ? '0 : gen_wave + 1'b1;
          DIR_WEST: gen_wave = (gen_wave == 0) ? WAVE_W'(NUM_WAVES - 1) : gen_wave - 1'b1;
          default: ;  // unused directions change nothing
        endcase
        n_navs++;
      end
      REQ_LOAD: begin
        // writes to a waveform number past the last one are dropped
        if (r.wave < NUM_WAVES) wave_mem[r.wave * TABLE_LEN + r.idx] = r.value;
        n_loads++;
      end
      default: n_other++;
    endcase
    o.sample = gen_sample;
    o.wave   = gen_wave;
    o.freq   = gen_freq;
    return o;
  endfunction

  // Queues a request; a tick headed for an unwritten entry gets a write of
  // that entry queued in front of it.
  function automatic void queue_req(logic [1:0] kind, logic [2:0] dir, logic [WAVE_W-1:0] wave,
                                    logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
    dds_req_t r;
    dds_req_t fill;
    logic [PHASE_W-1:0] ph;
    int a;
    r.kind  = kind;
    r.dir   = dir;
    r.wave  = wave;
    r.idx   = idx;
    r.value = value;
    case (kind)
      REQ_TICK: begin
        ph = plan_phase + plan_step;
        a  = plan_wave * TABLE_LEN + ph[15:8];
        if (!plan_written[a]) begin
          fill.kind  = REQ_LOAD;
          fill.dir   = DIR_NONE;
          fill.wave  = plan_wave;
          fill.idx   = ph[15:8];
          fill.value = SAMPLE_W'($urandom_range(4095));
          pending_reqs.push_back(fill);
          n_queued++;
          plan_written[a] = 1'b1;
        end
        plan_phase = ph;
      end
      REQ_NAV: begin
        case (dir)
          DIR_NORTH: begin
            plan_freq = (plan_freq + 1 >= NUM_FREQS) ? '0 : plan_freq + 1'b1;
            plan_step = phase_increment(plan_freq);
          end
          DIR_SOUTH: begin
            plan_freq = (plan_freq == 0) ? FREQ_W'(NUM_FREQS - 1) : plan_freq - 1'b1;
            plan_step = phase_increment(plan_freq);
          end
          DIR_EAST: plan_wave = (plan_wave + 1 >= NUM_WAVES) ? '0 : plan_wave + 1'b1;
          DIR_WEST: plan_wave = (plan_wave == 0) ? WAVE_W'(NUM_WAVES - 1) : plan_wave - 1'b1;
          default: ;
        endcase
      end
      REQ_LOAD: begin
        if (wave < NUM_WAVES) plan_written[wave * TABLE_LEN + idx] = 1'b1;
      end
      default: ;
    endcase
    pending_reqs.push_back(r);
    n_queued++;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: holds the payload until the transfer, then pulls the next
  // pending request unless it decides to idle this cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready)
        expected_outputs.push_back(advance_generator(cur_req));
      if (!req.valid || req.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          req.valid      <= 1'b1;
          req.req_type   <= cur_req.kind;
          req.direction  <= cur_req.dir;
          req.load_wave  <= cur_req.wave;
          req.load_index <= cur_req.idx;
          req.load_value <= cur_req.value;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else     rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every transfer is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dds_out_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        $error("result with nothing expected: dac_sample %0d wave_now %0d freq_now %0d",
               rsp.dac_sample, rsp.wave_now, rsp.freq_now);
        n_errors++;
      end else begin
        e = expected_outputs.pop_front();
        if (rsp.dac_sample !== e.sample) begin
          $error("dac_sample: expected %0d, got %0d", e.sample, rsp.dac_sample);
          n_errors++;
        end
        if (rsp.wave_now !== e.wave) begin
          $error("wave_now: expected %0d, got %0d", e.wave, rsp.wave_now);
          n_errors++;
        end
        if (rsp.freq_now !== e.freq) begin
          $error("freq_now: expected %0d, got %0d", e.freq, rsp.freq_now);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on transfer-free stretches.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, expected_outputs.size());
      $display("tb_table_dds_function_generator failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Lets the driver empty its queue and every result come back; no new
  // requests are queued meanwhile.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req.valid || expected_outputs.size() != 0)
      @(posedge clk);
  endtask

  // One random phase of n queued requests. Mostly ticks with navigation
  // sprinkled in so that the walk reaches every frequency and waveform; some
  // table rewrites, and a bit of noise (spare kind, unused directions,
  // out-of-range waveform).
  task automatic run_random(int s_pct, int r_pct, int n);
    int start;
    int pick;
    dds_req_t r;
    start = n_queued;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (n_queued - start < n) begin
      pick    = $urandom_range(99);
      r.dir   = 3'($urandom_range(7));
      r.wave  = WAVE_W'($urandom_range(7));
      r.idx   = IDX_W'($urandom_range(255));
      r.value = SAMPLE_W'($urandom_range(4095));
      if (pick < 55) begin
        r.kind = REQ_TICK;
      end else if (pick < 80) begin
        r.kind = REQ_NAV;
        if ($urandom_range(99) < 85) r.dir = 3'($urandom_range(DIR_WEST, DIR_NORTH));
      end else if (pick < 92) begin
        r.kind = REQ_LOAD;
        if ($urandom_range(99) < 80) r.wave = WAVE_W'($urandom_range(NUM_WAVES - 1));
      end else begin
        r.kind = REQ_SPARE;
      end
      queue_req(r.kind, r.dir, r.wave, r.idx, r.value);
    end
    wait_drained();
  endtask

  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.req_type   = REQ_TICK;
    req.direction  = DIR_NONE;
    req.load_wave  = '0;
    req.load_index = '0;
    req.load_value = '0;
    rsp.ready      = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    idle_cycles    = 0;
    n_queued       = 0;
    n_ticks = 0; n_navs = 0; n_loads = 0; n_other = 0; n_results = 0; n_errors = 0;

    // Shadow reset state: sine, 100 Hz (or the top index for short lists).
    gen_phase  = '0;
    gen_wave   = '0;
    gen_freq   = (NUM_FREQS > 3) ? FREQ_W'(3) : FREQ_W'(NUM_FREQS - 1);
    gen_step   = phase_increment(gen_freq);
    gen_sample = '0;

    plan_phase = gen_phase;
    plan_wave  = gen_wave;
    plan_freq  = gen_freq;
    plan_step  = gen_step;
    foreach (plan_written[i]) plan_written[i] = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: sample extremes, frequency and waveform wrap both ways,
    // ignored directions, spare request kind, dropped write, direction bits
    // on non-navigation items.
    queue_req(REQ_LOAD, DIR_NONE, '0, 8'h00, 12'hFFF);  // read by the first tick
    queue_req(REQ_TICK, DIR_SPARE, 3'd7, 8'hFF, 12'hFFF);
    queue_req(REQ_NAV, DIR_NORTH, '0, '0, '0);
    queue_req(REQ_NAV, DIR_NORTH, '0, '0, '0);
    queue_req(REQ_NAV, DIR_NORTH, '0, '0, '0);
    queue_req(REQ_NAV, DIR_NORTH, '0, '0, '0);        // top frequency
    queue_req(REQ_TICK, DIR_NONE, '0, '0, '0);
    queue_req(REQ_NAV, DIR_NORTH, '0, '0, '0);        // wraps to lowest
    queue_req(REQ_NAV, DIR_SOUTH, '0, '0, '0);        // wraps back to top
    queue_req(REQ_NAV, DIR_WEST, '0, '0, '0);         // sine wraps to last waveform
    queue_req(REQ_TICK, DIR_NORTH, '0, '0, '0);
    queue_req(REQ_NAV, DIR_EAST, '0, '0, '0);         // last wraps to sine
    queue_req(REQ_NAV, DIR_EAST, '0, '0, '0);
    queue_req(REQ_NAV, DIR_NONE, 3'd7, 8'hFF, 12'hFFF);
    queue_req(REQ_NAV, 3'd5, '0, '0, '0);
    queue_req(REQ_NAV, DIR_SPARE, '0, '0, '0);
    queue_req(REQ_SPARE, DIR_EAST, 3'd2, 8'h80, 12'h800);
    queue_req(REQ_LOAD, DIR_NORTH, 3'd7, 8'h00, 12'hFFF);  // waveform out of range
    queue_req(REQ_LOAD, DIR_NONE, 3'd5, 8'hFF, 12'h000);
    queue_req(REQ_LOAD, DIR_NONE, 3'd1, 8'hFF, 12'hFFF);
    queue_req(REQ_LOAD, DIR_NONE, 3'd1, 8'h00, 12'h000);
    queue_req(REQ_TICK, DIR_WEST, '0, '0, '0);
    queue_req(REQ_TICK, DIR_NONE, '0, '0, '0);
    queue_req(REQ_NAV, DIR_SOUTH, '0, '0, '0);
    queue_req(REQ_TICK, DIR_NONE, '0, '0, '0);
    wait_drained();

    // Random traffic under different flow-control mixes.
    run_random(0, 0, RANDOM_ITEMS / 4);
    run_random(60, 0, RANDOM_ITEMS / 4);
    run_random(0, 60, RANDOM_ITEMS / 4);
    run_random(21, 21, RANDOM_ITEMS / 4);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_outputs.size() != 0) begin
      $error("%0d results never arrived", expected_outputs.size());
      n_errors++;
    end

    $display("covered %0d ticks, %0d navigation events, %0d table writes, %0d spare requests",
             n_ticks, n_navs, n_loads, n_other);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_table_dds_function_generator passed");
    end else begin
      $display("tb_table_dds_function_generator failed");
    end
    $finish;
  end

endmodule
